>>> rtl/lkv_pkg.sv
package lkv_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W = 5;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	// Register word index taken from paddr[2].
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} ctrl_cmd_t;

endpackage

>>> rtl/lkv_cfg.sv
module lkv_cfg import lkv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [CAP_W-1:0]  capacity
);

	logic [CAP_W-1:0] capacity_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (wr_en && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY) begin
			prdata = {{(32-CAP_W){1'b0}}, capacity_q};
		end
	end

	assign capacity = capacity_q;

endmodule

>>> rtl/lkv_ctrl.sv
module lkv_ctrl import lkv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign cmd.load   = (state_q == ST_IDLE) & start;
	assign cmd.lookup = (state_q == ST_LOOKUP);
	assign cmd.commit = (state_q == ST_COMMIT);

endmodule

>>> rtl/lkv_dp.sv
module lkv_dp import lkv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	input  logic [CAP_W-1:0] capacity,
	input  logic             command,
	input  logic [KEY_W-1:0] lookup_key,
	input  logic [VAL_W-1:0] write_value,
	output logic             done,
	output logic             hit,
	output logic [VAL_W-1:0] read_value,
	output logic             evicted,
	output logic [KEY_W-1:0] evicted_key
);

	logic [KEY_W-1:0] keys_q   [MAX_ENTRIES];
	logic [VAL_W-1:0] values_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0] rank_q   [MAX_ENTRIES];
	logic [CNT_W-1:0] count_q;

	logic             is_put_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] val_s1;

	logic             hit_s2;
	logic [IDX_W-1:0] hit_idx_s2;
	logic             evict_s2;
	logic [IDX_W-1:0] oldest_idx_s2;
	logic             slot_ok_s2;
	logic [IDX_W-1:0] slot_idx_s2;

	logic             done_q;
	logic             hit_q;
	logic [VAL_W-1:0] read_value_q;
	logic             evicted_q;
	logic [KEY_W-1:0] evicted_key_q;

	logic [CNT_W-1:0] eff_cap;
	logic [IDX_W-1:0] last_rank;
	logic             match_any;
	logic [IDX_W-1:0] match_idx;
	logic             oldest_any;
	logic [IDX_W-1:0] oldest_idx;
	logic             need_evict;
	logic [MAX_ENTRIES-1:0] free_mask;
	logic             free_any;
	logic [IDX_W-1:0] free_idx;

	// Capacity zero counts as one; anything above the store size is clamped.
	always_comb begin
		if (capacity == '0) begin
			eff_cap = CNT_W'(1);
		end else if (int'(capacity) > MAX_ENTRIES) begin
			eff_cap = CNT_W'(MAX_ENTRIES);
		end else begin
			eff_cap = CNT_W'(capacity);
		end
	end

	// Valid ranks are distinct and run from 0 to count-1, so the least recent
	// entry is the valid one whose rank equals count-1.
	assign last_rank = IDX_W'(count_q - CNT_W'(1));

	always_comb begin
		match_any  = 1'b0;
		match_idx  = '0;
		oldest_any = 1'b0;
		oldest_idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && keys_q[i] == key_s1) begin
				match_any = 1'b1;
				match_idx = IDX_W'(i);
			end
			if (valid_q[i] && rank_q[i] == last_rank) begin
				oldest_any = 1'b1;
				oldest_idx = IDX_W'(i);
			end
		end
	end

	assign need_evict = is_put_s1 & ~match_any & (count_q >= eff_cap) & oldest_any;

	always_comb begin
		free_mask = ~valid_q;
		if (need_evict) begin
			free_mask[oldest_idx] = 1'b1;
		end
		free_any = 1'b0;
		free_idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (free_mask[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_put_s1 <= (command == CMD_PUT);
			key_s1    <= lookup_key;
			val_s1    <= write_value;
		end
		if (cmd.lookup) begin
			hit_s2        <= match_any;
			hit_idx_s2    <= match_idx;
			evict_s2      <= need_evict;
			oldest_idx_s2 <= oldest_idx;
			slot_ok_s2    <= free_any;
			slot_idx_s2   <= free_idx;
		end
	end

	// Key and value storage holds no reset: only valid entries are ever read.
	always_ff @(posedge clk) begin
		if (cmd.commit && is_put_s1) begin
			if (hit_s2) begin
				values_q[hit_idx_s2] <= val_s1;
			end else if (slot_ok_s2) begin
				keys_q[slot_idx_s2]   <= key_s1;
				values_q[slot_idx_s2] <= val_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (hit_s2) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (valid_q[i] && rank_q[i] < rank_q[hit_idx_s2]) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
				rank_q[hit_idx_s2] <= '0;
			end else if (is_put_s1 && slot_ok_s2) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (valid_q[i] && !(evict_s2 && IDX_W'(i) == oldest_idx_s2)) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
				// The new entry may land in the slot that was just evicted.
				if (evict_s2) begin
					if (oldest_idx_s2 != slot_idx_s2) begin
						valid_q[oldest_idx_s2] <= 1'b0;
						rank_q[oldest_idx_s2]  <= '0;
					end
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
				valid_q[slot_idx_s2] <= 1'b1;
				rank_q[slot_idx_s2]  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q         <= hit_s2;
			read_value_q  <= (hit_s2 && !is_put_s1) ? values_q[hit_idx_s2] : MISS_VALUE;
			evicted_q     <= evict_s2;
			evicted_key_q <= evict_s2 ? keys_q[oldest_idx_s2] : '0;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

>>> rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// A command taken with start steps through the lookup and commit states, and done is
// registered from the commit step; busy is high while in lookup and commit.
// A new command is taken only back in idle, once the last one has passed the commit step.
// The receiver cannot stall: done is high for exactly one cycle per result.
// Reset clears valid marks, recency ranks and the entry count; capacity resets to 16.
module lru_key_value_cache import lkv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [KEY_W-1:0]  lookup_key,
	input  logic [VAL_W-1:0]  write_value,
	output logic              done,
	output logic              hit,
	output logic [VAL_W-1:0]  read_value,
	output logic              evicted,
	output logic [KEY_W-1:0]  evicted_key,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	ctrl_cmd_t        cmd;
	logic [CAP_W-1:0] capacity;

	lkv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	lkv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	lkv_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.capacity    (capacity),
		.command     (command),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.done        (done),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule

>>> tb/tb_lru_key_value_cache.sv
`timescale 1ns / 100ps

module tb_lru_key_value_cache;
	import lkv_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 6;
	localparam int REPORT_LIMIT = 10;
	localparam logic [ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
	localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} access_result_t;

	localparam access_result_t MISSED = '{1'b0, MISS_VALUE, 1'b0, '0};
	localparam access_result_t PUT_HIT = '{1'b1, MISS_VALUE, 1'b0, '0};

	typedef enum bit {ROW_ACCESS, ROW_CAPACITY} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic             cmd;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] data;
		bit               typed;
		access_result_t   result;
	} stim_row_t;

	localparam int NUM_ROWS = 25;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              command;
	logic [KEY_W-1:0]  lookup_key;
	logic [VAL_W-1:0]  write_value;
	logic              done;
	logic              hit;
	logic [VAL_W-1:0]  read_value;
	logic              evicted;
	logic [KEY_W-1:0]  evicted_key;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// Model of the cache contents, updated as each beat is accepted.
	logic [KEY_W-1:0] held_key [MAX_ENTRIES];
	logic [VAL_W-1:0] held_val [MAX_ENTRIES];
	bit               held_valid [MAX_ENTRIES];
	int               held_rank [MAX_ENTRIES];
	int               held_count;
	logic [CAP_W-1:0] cache_cap;

	access_result_t pending_results [$];
	bit             typed_pending;
	access_result_t typed_result;
	int             mismatches;
	int             cycle_count;
	stim_row_t      directed_rows [NUM_ROWS];

	lru_key_value_cache DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.lookup_key(lookup_key),
		.write_value(write_value),
		.done(done),
		.hit(hit),
		.read_value(read_value),
		.evicted(evicted),
		.evicted_key(evicted_key),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int effective_capacity();
		if (cache_cap == 0)
			return 1;
		if (cache_cap > MAX_ENTRIES)
			return MAX_ENTRIES;
		return int'(cache_cap);
	endfunction

	function automatic access_result_t cache_access(input logic is_put,
			input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] data);
		int found;
		int oldest;
		int slot;
		int i;
		access_result_t res;
		found = -1;
		oldest = -1;
		slot = -1;
		res = MISSED;
		for (i = 0; i < MAX_ENTRIES; i++) begin
			if (found < 0 && held_valid[i] && held_key[i] == key)
				found = i;
		end
		if (found >= 0) begin
			res.hit = 1'b1;
			if (is_put)
				held_val[found] = data;
			else
				res.read_value = held_val[found];
			for (i = 0; i < MAX_ENTRIES; i++) begin
				if (held_valid[i] && held_rank[i] < held_rank[found])
					held_rank[i]++;
			end
			held_rank[found] = 0;
		end else if (is_put) begin
			if (held_count >= effective_capacity()) begin
				for (i = 0; i < MAX_ENTRIES; i++) begin
					if (held_valid[i] && (oldest < 0 || held_rank[i] > held_rank[oldest]))
						oldest = i;
				end
				if (oldest >= 0) begin
					res.evicted = 1'b1;
					res.evicted_key = held_key[oldest];
					held_valid[oldest] = 1'b0;
					held_rank[oldest] = 0;
					held_count--;
				end
			end
			for (i = 0; i < MAX_ENTRIES; i++) begin
				if (slot < 0 && !held_valid[i])
					slot = i;
			end
			if (slot >= 0) begin
				for (i = 0; i < MAX_ENTRIES; i++) begin
					if (held_valid[i])
						held_rank[i]++;
				end
				held_key[slot] = key;
				held_val[slot] = data;
				held_valid[slot] = 1'b1;
				held_rank[slot] = 0;
				held_count++;
			end
		end
		return res;
	endfunction

	function automatic void report_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
	endfunction

	// Result monitor and acceptance tracking share one edge: the result is
	// checked first since it always belongs to an earlier beat.
	always @(posedge clk) begin : observe
		access_result_t seen;
		access_result_t want;
		if (arst_n) begin
			if (done) begin
				seen = '{hit, read_value, evicted, evicted_key};
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result with none pending: hit=%0b rd=%h ev=%0b evk=%h",
						hit, read_value, evicted, evicted_key));
				end else begin
					want = pending_results.pop_front();
					if (seen !== want)
						report_mismatch($sformatf(
							"expected hit=%0b rd=%h ev=%0b evk=%h, got hit=%0b rd=%h ev=%0b evk=%h",
							want.hit, want.read_value, want.evicted, want.evicted_key,
							seen.hit, seen.read_value, seen.evicted, seen.evicted_key));
				end
			end
			if (start && !busy) begin
				want = cache_access(command == CMD_PUT, lookup_key, write_value);
				pending_results.push_back(typed_pending ? typed_result : want);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			command <= 1'($urandom_range(0, 1));
			lookup_key <= $urandom();
			write_value <= $urandom();
		end
	endtask

	task automatic issue_access(input logic cmd, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] data, input bit typed, input access_result_t result);
		@(negedge clk);
		typed_pending = typed;
		typed_result = result;
		start <= 1'b1;
		command <= cmd;
		lookup_key <= key;
		write_value <= data;
		do @(posedge clk); while (busy);
	endtask

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == REG_CAPACITY)
			cache_cap = data[CAP_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_capacity_readback();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CAP_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CAP_W-1:0] !== cache_cap)
			report_mismatch($sformatf("capacity read back %h, expected %h",
				prdata[CAP_W-1:0], cache_cap));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Registers are only touched once every outstanding result has come back.
	task automatic drain();
		idle_cycles(1);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [31:0] data);
		drain();
		reg_write(CAP_ADDR, data);
		check_capacity_readback();
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [KEY_W-1:0] pool_key();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return '0;
			default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		int phase_caps [12];
		logic [KEY_W-1:0] key_pool [$];
		logic [KEY_W-1:0] key;
		bit burst;
		int pool_size;
		int p;
		int n;

		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_GET;
		lookup_key = '0;
		write_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		typed_pending = 1'b0;
		typed_result = MISSED;
		mismatches = 0;
		held_count = 0;
		cache_cap = CAPACITY_RESET;
		for (n = 0; n < MAX_ENTRIES; n++) begin
			held_key[n] = '0;
			held_val[n] = '0;
			held_valid[n] = 1'b0;
			held_rank[n] = 0;
		end

		// Order of recency is noted after the rows that change it (most recent first).
		directed_rows = '{
			'{ROW_ACCESS, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISSED},
			'{ROW_ACCESS, CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, MISSED},
			'{ROW_ACCESS, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
				'{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
			'{ROW_ACCESS, CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, MISSED},
			// A put hit still reads back the miss value.
			'{ROW_ACCESS, CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, PUT_HIT},
			// write_value is ignored on a get.
			'{ROW_ACCESS, CMD_GET, 32'h8000_0000, 32'h1234_5678, 1'b1,
				'{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
			'{ROW_ACCESS, CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, MISSED},
			'{ROW_ACCESS, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
				'{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
			'{ROW_ACCESS, CMD_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1, MISSED},
			'{ROW_ACCESS, CMD_GET, 32'h0000_0000, 32'hAAAA_AAAA, 1'b1,
				'{1'b1, 32'h0000_0000, 1'b0, 32'h0}},
			// 0, 7FFFFFFF, 80000000. A capacity of zero acts as one, below the count.
			'{ROW_CAPACITY, CMD_GET, 32'h0, 32'h0000_0000, 1'b0, MISSED},
			'{ROW_ACCESS, CMD_PUT, 32'h0000_0001, 32'h5555_5555, 1'b1,
				'{1'b0, MISS_VALUE, 1'b1, 32'h8000_0000}},
			'{ROW_ACCESS, CMD_PUT, 32'h0000_0002, 32'h2222_2222, 1'b1,
				'{1'b0, MISS_VALUE, 1'b1, 32'h7FFF_FFFF}},
			'{ROW_ACCESS, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, MISSED},
			'{ROW_ACCESS, CMD_PUT, 32'h0000_0001, 32'h6666_6666, 1'b1, PUT_HIT},
			// 1, 2, 0: key zero goes out with the evicted flag set.
			'{ROW_ACCESS, CMD_PUT, 32'h0000_0003, 32'h3333_3333, 1'b1,
				'{1'b0, MISS_VALUE, 1'b1, 32'h0000_0000}},
			'{ROW_ACCESS, CMD_PUT, 32'h0000_0004, 32'h4444_4444, 1'b1,
				'{1'b0, MISS_VALUE, 1'b1, 32'h0000_0002}},
			// Capacity 31 acts as the full store; upper data bits are dropped.
			'{ROW_CAPACITY, CMD_GET, 32'h0, 32'hFFFF_FFFF, 1'b0, MISSED},
			'{ROW_ACCESS, CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, MISSED},
			'{ROW_ACCESS, CMD_GET, 32'h0000_0004, 32'h0000_0000, 1'b1,
				'{1'b1, 32'h4444_4444, 1'b0, 32'h0}},
			// 4, FFFFFFFF, 3, 1 with capacity two.
			'{ROW_CAPACITY, CMD_GET, 32'h0, 32'h0000_0002, 1'b0, MISSED},
			'{ROW_ACCESS, CMD_PUT, 32'h0000_0005, 32'h5555_0000, 1'b1,
				'{1'b0, MISS_VALUE, 1'b1, 32'h0000_0001}},
			'{ROW_ACCESS, CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, MISSED},
			'{ROW_CAPACITY, CMD_GET, 32'h0, 32'h0000_0010, 1'b0, MISSED},
			'{ROW_ACCESS, CMD_PUT, 32'h0000_0006, 32'h6666_0000, 1'b1, MISSED}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_capacity_readback();
		for (n = 0; n < NUM_ROWS; n++) begin
			if (directed_rows[n].kind == ROW_CAPACITY) begin
				set_capacity(directed_rows[n].data);
			end else begin
				issue_access(directed_rows[n].cmd, directed_rows[n].key, directed_rows[n].data,
					directed_rows[n].typed, directed_rows[n].result);
				idle_cycles(pick_gap());
			end
		end

		phase_caps = '{16, 1, 0, 5, 31, 2, 16, 9, 3, 20, 16, 7};
		for (p = 0; p < 12; p++) begin
			drain();
			// A write to the unused register index must leave capacity alone.
			reg_write(SPARE_ADDR, $urandom());
			set_capacity(($urandom() & ~32'h1F) | phase_caps[p]);
			burst = (p % 3 == 1);
			pool_size = effective_capacity() + $urandom_range(1, 6);
			key_pool.delete();
			repeat (pool_size) key_pool.push_back(pool_key());
			repeat (140) begin
				if ($urandom_range(0, 99) < 85)
					key = key_pool[$urandom_range(0, pool_size - 1)];
				else
					key = $urandom();
				issue_access(1'($urandom_range(0, 1)), key, $urandom(), 1'b0, MISSED);
				if (!burst)
					idle_cycles(pick_gap());
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
